// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl, sampled on clk_i and held off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WFR_NEVER(label, cond, msg) \
  `WFR_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/wfr_pkg.sv =====
// ----------------------------------------------------------------------------
// wfr_pkg
// Types and constants of the waypoint frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wfr_pkg;

  localparam int unsigned FrameBytes = 12;
  localparam int unsigned PosW       = 4;

  localparam logic [7:0] HdrWp0 = 8'h57;  // 'W'
  localparam logic [7:0] HdrWp1 = 8'h50;  // 'P'
  localparam logic [7:0] HdrFm0 = 8'h46;  // 'F'
  localparam logic [7:0] HdrFm1 = 8'h4D;  // 'M'
  localparam logic [7:0] HdrDe0 = 8'h44;  // 'D'
  localparam logic [7:0] HdrDe1 = 8'h45;  // 'E'

  localparam logic [31:0]        DelMarker = 32'd127;
  localparam logic signed [31:0] MinLatRst = 32'sd10000000;
  localparam logic signed [31:0] MinLngRst = 32'sd100000000;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOF  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_WAYPOINT = 2'd0,
    KIND_FOLLOW   = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_STORED  = 3'd1,
    ACT_DROPPED = 3'd2,
    ACT_FOLLOW  = 3'd3,
    ACT_CLEARED = 3'd4
  } act_e;

  typedef enum logic [0:0] {
    CFG_MIN_LAT = 1'b0,
    CFG_MIN_LNG = 1'b1
  } cfg_idx_e;

  // decoded view of the frame buffer
  typedef struct packed {
    logic               hdr_hit;
    kind_e              hdr_kind;
    logic               sum_ok;
    logic signed [31:0] lat;
    logic signed [31:0] lng;
  } frame_dec_t;

endpackage

// ===== hdl/wfr_if.sv =====
// ----------------------------------------------------------------------------
// wfr_in_if / wfr_out_if
// Valid/ready channels carrying receiver commands and status results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic [4:0] entry_index;

  modport source (output valid, op, rx_byte, entry_index, input ready);
  modport sink   (input valid, op, rx_byte, entry_index, output ready);
endinterface

interface wfr_out_if #(
  parameter int unsigned CntW = 6
);
  logic               valid;
  logic               ready;
  logic               frame_ok;
  logic [1:0]         frame_kind;
  logic [2:0]         action;
  logic               delete_header_seen;
  logic [CntW-1:0]    waypoint_count;
  logic signed [31:0] follow_latitude;
  logic signed [31:0] follow_longitude;
  logic signed [31:0] entry_latitude;
  logic signed [31:0] entry_longitude;

  modport source (
    output valid, frame_ok, frame_kind, action, delete_header_seen, waypoint_count,
           follow_latitude, follow_longitude, entry_latitude, entry_longitude,
    input  ready
  );
  modport sink (
    input  valid, frame_ok, frame_kind, action, delete_header_seen, waypoint_count,
           follow_latitude, follow_longitude, entry_latitude, entry_longitude,
    output ready
  );
endinterface

// ===== hdl/waypoint_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// waypoint_frame_receiver
// Serial frame receiver keeping a waypoint table and a follow-me target.
// ----------------------------------------------------------------------------
// Received bytes, end-of-frame markers and table reads all stream through at
// one item per cycle when not stalled, and every item gives one status beat
// via the input and then the result register, alongside the registered read
// of the waypoint table RAM. A stalled output holds the input register full
// and then drops in_i.ready; no item is ever lost. There is no clearing pass
// after reset: clearing the table only zeroes the count, and slots at or above
// the count always read as zero. The user must write min_latitude and
// min_longitude through cfg_we_i while idle; the block does not enforce it.
`timescale 1ns / 1ps

module waypoint_frame_receiver #(
  parameter int unsigned WAYPOINT_SLOTS = 32,
  localparam int unsigned CntW = $clog2(WAYPOINT_SLOTS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_data_i,
  wfr_in_if.sink                     in_i,
  wfr_out_if.source                  out_o
);
  import wfr_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AddrW  = (WAYPOINT_SLOTS > 1) ? $clog2(WAYPOINT_SLOTS) : 1;
  localparam int unsigned IdxCmpW = (CntW > 5) ? CntW : 5;

  // configuration
  logic signed [31:0] min_lat_q, min_lng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lat_q <= MinLatRst;
      min_lng_q <= MinLngRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_LAT: min_lat_q <= $signed(cfg_data_i);
        CFG_MIN_LNG: min_lng_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  op_e        s1_op_q;
  logic [7:0] s1_byte_q;
  logic [4:0] s1_idx_q;
  logic       s1_fire, s2_ready, in_fire;

  logic out_valid_q;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_i.ready = !s1_valid_q || s2_ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= op_e'(in_i.op);
      s1_byte_q <= in_i.rx_byte;
      s1_idx_q  <= in_i.entry_index;
    end
  end

  // frame buffer and decode
  frame_dec_t dec;

  wfr_frame_buf u_frame_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_fire),
    .op_i   (s1_op_q),
    .byte_i (s1_byte_q),
    .dec_o  (dec)
  );

  // frame state
  kind_e              kind_q, kind_d;
  logic [CntW-1:0]    count_q, count_d;
  logic signed [31:0] tgt_lat_q, tgt_lat_d, tgt_lng_q, tgt_lng_d;
  logic               ok_d, del_d, hit_d, tbl_we;
  act_e               act_d;
  logic               above, full;

  assign above = (dec.lat > min_lat_q) && (dec.lng > min_lng_q);
  assign full  = (count_q >= CntW'(WAYPOINT_SLOTS));

  always_comb begin
    kind_d    = kind_q;
    count_d   = count_q;
    tgt_lat_d = tgt_lat_q;
    tgt_lng_d = tgt_lng_q;
    ok_d      = 1'b0;
    del_d     = 1'b0;
    act_d     = ACT_NONE;
    tbl_we    = 1'b0;
    hit_d     = 1'b0;
    case (s1_op_q)
      OP_EOF: begin
        if (dec.hdr_hit) begin
          kind_d = dec.hdr_kind;
        end
        del_d = dec.hdr_hit && (dec.hdr_kind == KIND_DELETE);
        if (dec.sum_ok) begin
          ok_d = 1'b1;
          case (kind_d)
            KIND_WAYPOINT: begin
              if (above && !full) begin
                tbl_we  = 1'b1;
                count_d = count_q + CntW'(1);
                act_d   = ACT_STORED;
              end else begin
                act_d = ACT_DROPPED;
              end
            end
            KIND_DELETE: begin
              if (dec.lat == DelMarker && dec.lng == DelMarker) begin
                count_d = '0;
                act_d   = ACT_CLEARED;
              end
            end
            KIND_FOLLOW: begin
              if (above) begin
                tgt_lat_d = dec.lat;
                tgt_lng_d = dec.lng;
                act_d     = ACT_FOLLOW;
              end
            end
            default: ;
          endcase
        end
      end
      OP_READ: hit_d = (IdxCmpW'(s1_idx_q) < IdxCmpW'(count_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_NONE;
      count_q   <= '0;
      tgt_lat_q <= '0;
      tgt_lng_q <= '0;
    end else if (s1_fire) begin
      kind_q    <= kind_d;
      count_q   <= count_d;
      tgt_lat_q <= tgt_lat_d;
      tgt_lng_q <= tgt_lng_d;
    end
  end

  // waypoint table, latitude in the upper half
  logic [63:0] tbl_rdata;

  wfr_ram #(
    .Width (64),
    .Depth (WAYPOINT_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (s1_fire && tbl_we),
    .waddr_i (AddrW'(count_q)),
    .wdata_i ({dec.lat, dec.lng}),
    .re_i    (s1_fire),
    .raddr_i (AddrW'(s1_idx_q)),
    .rdata_o (tbl_rdata)
  );

  // result register; frame state holds while the output beat waits
  logic ok_q, del_q, hit_q;
  act_e act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ok_q  <= ok_d;
      del_q <= del_d;
      hit_q <= hit_d;
      act_q <= act_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.frame_ok           = ok_q;
  assign out_o.frame_kind         = kind_q;
  assign out_o.action             = act_q;
  assign out_o.delete_header_seen = del_q;
  assign out_o.waypoint_count     = count_q;
  assign out_o.follow_latitude    = tgt_lat_q;
  assign out_o.follow_longitude   = tgt_lng_q;
  assign out_o.entry_latitude     = hit_q ? $signed(tbl_rdata[63:32]) : '0;
  assign out_o.entry_longitude    = hit_q ? $signed(tbl_rdata[31:0]) : '0;

  `WFR_NEVER(count_bound_a, count_q > CntW'(WAYPOINT_SLOTS), "waypoint count past table size")
  `WFR_ASSERT(store_counts_a, (s1_fire && act_d == ACT_STORED) |=>
              (count_q == $past(count_q) + CntW'(1)), "stored waypoint not counted")
  `WFR_ASSERT(clear_zeroes_a, (s1_fire && act_d == ACT_CLEARED) |=> (count_q == '0),
              "table clear left a nonzero count")
  `WFR_ASSERT(stall_freezes_a, (out_valid_q && !out_o.ready) |=>
              ($stable(count_q) && $stable(kind_q) && $stable(tgt_lat_q)),
              "frame state moved under a stalled result")

endmodule

// ===== hdl/wfr_ram.sv =====
// ----------------------------------------------------------------------------
// wfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/wfr_frame_buf.sv =====
// ----------------------------------------------------------------------------
// wfr_frame_buf
// Frame byte buffer with fill position, header match and checksum decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wfr_frame_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  wfr_pkg::op_e      op_i,
  input  logic [7:0]        byte_i,
  output wfr_pkg::frame_dec_t dec_o
);
  import wfr_pkg::*;
  `include "assert_macros.svh"

  logic [7:0]      bytes_q [FrameBytes];
  logic [PosW-1:0] pos_q, pos_d;
  logic            wr_en;
  logic [7:0]      sum_x, sum_o;

  assign wr_en = step_i && (op_i == OP_BYTE) && (pos_q < PosW'(FrameBytes));

  always_comb begin
    pos_d = pos_q;
    if (step_i) begin
      case (op_i)
        OP_BYTE: if (wr_en) pos_d = pos_q + PosW'(1);
        OP_EOF:  pos_d = '0;
        default: pos_d = pos_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < FrameBytes; i++) bytes_q[i] <= '0;
    end else begin
      pos_q <= pos_d;
      if (wr_en) begin
        bytes_q[pos_q] <= byte_i;
      end
    end
  end

  // xor and or over the eight payload bytes
  always_comb begin
    sum_x = '0;
    sum_o = '0;
    for (int i = 2; i < 10; i++) begin
      sum_x = sum_x ^ bytes_q[i];
      sum_o = sum_o | bytes_q[i];
    end
  end

  always_comb begin
    dec_o.hdr_hit  = 1'b1;
    dec_o.hdr_kind = KIND_NONE;
    if (bytes_q[0] == HdrWp0 && bytes_q[1] == HdrWp1) begin
      dec_o.hdr_kind = KIND_WAYPOINT;
    end else if (bytes_q[0] == HdrFm0 && bytes_q[1] == HdrFm1) begin
      dec_o.hdr_kind = KIND_FOLLOW;
    end else if (bytes_q[0] == HdrDe0 && bytes_q[1] == HdrDe1) begin
      dec_o.hdr_kind = KIND_DELETE;
    end else begin
      dec_o.hdr_hit = 1'b0;
    end
    dec_o.sum_ok = (sum_x == bytes_q[10]) && (sum_o == bytes_q[11]) && (sum_o != 8'd0);
    // little-endian words
    dec_o.lat = $signed({bytes_q[5], bytes_q[4], bytes_q[3], bytes_q[2]});
    dec_o.lng = $signed({bytes_q[9], bytes_q[8], bytes_q[7], bytes_q[6]});
  end

  `WFR_NEVER(pos_in_range_a, pos_q > PosW'(FrameBytes), "frame position past buffer end")
  `WFR_ASSERT(eof_rewinds_a, (step_i && op_i == OP_EOF) |=> (pos_q == '0),
              "end of frame did not rewind position")

endmodule

// ===== bench/waypoint_frame_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// waypoint_frame_receiver_tb
// Self-checking bench for the waypoint frame receiver.
// ----------------------------------------------------------------------------
// Frames are streamed in byte by byte through the command channel. Each command
// is mirrored in a local copy of the receiver state, and every status beat
// that comes back is compared with the status this copy gives. Directed frames
// cover the header kinds, the checksum rules, the limits and the frame length
// corner cases. Random traffic then runs under several limit settings, with
// gaps and stalls on both channels, plus one table fill without any.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_frame_receiver_tb;
  import wfr_pkg::*;

  localparam int         WaypointSlots = 32;
  localparam int         StallLimit    = 2000;
  localparam logic [1:0] OpUnused      = 2'd3;
  localparam int         FlawNone      = 0;
  localparam int         FlawXor       = 1;
  localparam int         FlawOr        = 2;

  typedef struct packed {
    logic        frame_ok;
    kind_e       kind;
    act_e        action;
    logic        del_seen;
    logic [5:0]  count;
    logic [31:0] fm_lat;
    logic [31:0] fm_lng;
    logic [31:0] entry_lat;
    logic [31:0] entry_lng;
  } status_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  wfr_in_if             in_if ();
  wfr_out_if #(.CntW(6)) out_if ();

  waypoint_frame_receiver #(
    .WAYPOINT_SLOTS(WaypointSlots)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver state as the status beats should show it
  logic [7:0]         frame_buf [FrameBytes];
  int                 rx_pos = 0;
  kind_e              cur_kind = KIND_NONE;
  logic [31:0]        wp_lat [WaypointSlots];
  logic [31:0]        wp_lng [WaypointSlots];
  int                 wp_count = 0;
  logic [31:0]        tgt_lat = '0;
  logic [31:0]        tgt_lng = '0;
  logic signed [31:0] min_lat = MinLatRst;
  logic signed [31:0] min_lng = MinLngRst;

  status_t status_q [$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;
  logic    gaps_on = 1'b1;

  function automatic logic above_limits(input logic [31:0] lat, input logic [31:0] lng);
    return ($signed(lat) > min_lat) && ($signed(lng) > min_lng);
  endfunction

  task automatic predict_status(input logic [1:0] op, input logic [7:0] rxb,
                                input logic [4:0] idx);
    status_t     s;
    logic [7:0]  x;
    logic [7:0]  o;
    logic [31:0] lat;
    logic [31:0] lng;
    int          i;
    s = '0;
    x = '0;
    o = '0;
    if (op == OP_BYTE) begin
      // bytes past the end of the buffer are dropped
      if (rx_pos < FrameBytes) begin
        frame_buf[rx_pos] = rxb;
        rx_pos++;
      end
    end else if (op == OP_EOF) begin
      if (frame_buf[0] == HdrWp0 && frame_buf[1] == HdrWp1) begin
        cur_kind = KIND_WAYPOINT;
      end else if (frame_buf[0] == HdrFm0 && frame_buf[1] == HdrFm1) begin
        cur_kind = KIND_FOLLOW;
      end else if (frame_buf[0] == HdrDe0 && frame_buf[1] == HdrDe1) begin
        cur_kind = KIND_DELETE;
        s.del_seen = 1'b1;
      end
      for (i = 2; i < 10; i++) begin
        x ^= frame_buf[i];
        o |= frame_buf[i];
      end
      lat = {frame_buf[5], frame_buf[4], frame_buf[3], frame_buf[2]};
      lng = {frame_buf[9], frame_buf[8], frame_buf[7], frame_buf[6]};
      if (x == frame_buf[10] && o == frame_buf[11] && o != 8'h00) begin
        s.frame_ok = 1'b1;
        case (cur_kind)
          KIND_WAYPOINT: begin
            if (above_limits(lat, lng) && wp_count < WaypointSlots) begin
              wp_lat[wp_count] = lat;
              wp_lng[wp_count] = lng;
              wp_count++;
              s.action = ACT_STORED;
            end else begin
              s.action = ACT_DROPPED;
            end
          end
          KIND_DELETE: begin
            if (lat == DelMarker && lng == DelMarker) begin
              for (i = 0; i < WaypointSlots; i++) begin
                wp_lat[i] = '0;
                wp_lng[i] = '0;
              end
              wp_count = 0;
              s.action = ACT_CLEARED;
            end
          end
          KIND_FOLLOW: begin
            if (above_limits(lat, lng)) begin
              tgt_lat = lat;
              tgt_lng = lng;
              s.action = ACT_FOLLOW;
            end
          end
          default: begin
          end
        endcase
      end
      rx_pos = 0;
    end else if (op == OP_READ) begin
      if (idx < wp_count) begin
        s.entry_lat = wp_lat[idx];
        s.entry_lng = wp_lng[idx];
      end
    end
    s.kind   = cur_kind;
    s.count  = wp_count[5:0];
    s.fm_lat = tgt_lat;
    s.fm_lng = tgt_lng;
    status_q.push_back(s);
  endtask

  // one command beat; valid stays up unless a gap follows
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] rxb,
                          input logic [4:0] idx);
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.rx_byte     <= rxb;
    in_if.entry_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_status(op, rxb, idx);
    items_sent++;
    if (gaps_on && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // len bytes of a frame, then end of frame; bytes past twelve are random
  task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                            input logic [31:0] lat, input logic [31:0] lng,
                            input int flaw, input int len);
    logic [7:0] fb [16];
    logic [7:0] x;
    logic [7:0] o;
    int         i;
    x = '0;
    o = '0;
    fb[0] = h0;
    fb[1] = h1;
    {fb[5], fb[4], fb[3], fb[2]} = lat;
    {fb[9], fb[8], fb[7], fb[6]} = lng;
    for (i = 2; i < 10; i++) begin
      x ^= fb[i];
      o |= fb[i];
    end
    fb[10] = (flaw == FlawXor) ? x ^ (8'h01 << $urandom_range(7)) : x;
    fb[11] = (flaw == FlawOr) ? o ^ (8'h01 << $urandom_range(7)) : o;
    for (i = 12; i < 16; i++) fb[i] = 8'($urandom);
    for (i = 0; i < len; i++) send_cmd(OP_BYTE, fb[i], 5'($urandom));
    send_cmd(OP_EOF, 8'($urandom), 5'($urandom));
  endtask

  function automatic logic [31:0] pick_coord(input logic signed [31:0] floor);
    longint v;
    case ($urandom_range(7))
      0: return $urandom;
      1: return floor;
      2: return DelMarker;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: begin
        v = longint'(floor) + 1 + longint'($urandom_range(100000));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        return v[31:0];
      end
    endcase
  endfunction

  task automatic drain_status();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic [31:0] lat, input logic [31:0] lng);
    drain_status();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MIN_LAT;
    cfg_data_i <= lat;
    @(posedge clk_i);
    min_lat = lat;
    cfg_idx_i  <= CFG_MIN_LNG;
    cfg_data_i <= lng;
    @(posedge clk_i);
    min_lng = lng;
    cfg_we_i <= 1'b0;
  endtask

  task automatic read_slot();
    if (wp_count > 0 && $urandom_range(3) != 0) begin
      send_cmd(OP_READ, 8'($urandom), 5'($urandom_range(wp_count - 1)));
    end else begin
      send_cmd(OP_READ, 8'($urandom), 5'($urandom));
    end
  endtask

  // status before any frame: empty table, no kind yet, all-zero buffer
  task automatic test_status_idle();
    send_cmd(OP_READ, 8'hff, 5'd0);
    send_cmd(OP_READ, 8'h00, 5'd31);
    send_cmd(OpUnused, 8'ha5, 5'd17);
    send_cmd(OP_EOF, 8'h5a, 5'd10);
  endtask

  task automatic test_frame_cases();
    send_frame(HdrWp0, HdrWp1, 32'h7fffffff, 32'h7fffffff, FlawNone, 12);
    // latitude equal to the limit is not above it
    send_frame(HdrWp0, HdrWp1, MinLatRst, 32'h7fff0000, FlawNone, 12);
    send_frame(HdrFm0, HdrFm1, 32'd20000000, 32'd200000000, FlawNone, 12);
    send_frame(HdrFm0, HdrFm1, 32'd30000000, MinLngRst, FlawNone, 12);
    // unknown header keeps follow-me
    send_frame(8'h58, 8'h59, 32'd40000000, 32'd300000000, FlawNone, 12);
    send_frame(HdrWp0, HdrWp1, 32'd50000000, 32'd400000000, FlawXor, 12);
    send_frame(HdrWp0, HdrWp1, 32'd50000000, 32'd400000000, FlawOr, 12);
    send_frame(HdrDe0, HdrDe1, DelMarker, 32'd128, FlawNone, 12);
    // overlong frame, extra bytes dropped
    send_frame(HdrWp0, HdrWp1, 32'd60000000, 32'd500000000, FlawNone, 15);
    // short frame reuses the tail of the previous one
    send_frame(HdrDe0, HdrDe1, 32'h0, 32'h0, FlawNone, 2);
    send_frame(HdrWp0, HdrWp1, 32'h0, 32'h0, FlawNone, 12);
    send_cmd(OP_READ, 8'($urandom), 5'd0);
    send_cmd(OP_READ, 8'($urandom), 5'd1);
    send_cmd(OP_READ, 8'($urandom), 5'd2);
    send_frame(HdrDe0, HdrDe1, DelMarker, DelMarker, FlawNone, 12);
    send_cmd(OP_READ, 8'($urandom), 5'd0);
  endtask

  // fill every slot, overflow once, read all back, then clear
  task automatic test_table_fill();
    int i;
    while (wp_count < WaypointSlots) begin
      send_frame(HdrWp0, HdrWp1, $urandom_range(32'h7fffffff), $urandom, FlawNone, 12);
      if ($urandom_range(3) == 0) read_slot();
    end
    send_frame(HdrWp0, HdrWp1, 32'h7fffffff, 32'h7fffffff, FlawNone, 12);
    for (i = 0; i < WaypointSlots; i++) send_cmd(OP_READ, 8'($urandom), 5'(i));
    send_frame(HdrDe0, HdrDe1, DelMarker, DelMarker, FlawNone, 12);
    send_cmd(OP_READ, 8'($urandom), 5'd31);
  endtask

  task automatic test_random_traffic(input int n_items);
    int          stop_at;
    int          r;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic [31:0] lat;
    logic [31:0] lng;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      lat = pick_coord(min_lat);
      lng = pick_coord(min_lng);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          h0 = HdrWp0;
          h1 = HdrWp1;
        end
        10, 11, 12, 13: begin
          h0 = HdrFm0;
          h1 = HdrFm1;
        end
        14, 15: begin
          h0 = HdrDe0;
          h1 = HdrDe1;
          if ($urandom_range(1)) begin
            lat = DelMarker;
            lng = DelMarker;
          end
        end
        default: begin
          h0 = 8'($urandom);
          h1 = 8'($urandom);
        end
      endcase
      if (r < 70) begin
        send_frame(h0, h1, lat, lng, FlawNone, 12);
      end else if (r < 82) begin
        send_frame(h0, h1, lat, lng, $urandom_range(2), $urandom_range(15));
      end else if (r < 94) begin
        read_slot();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_cmd(2'($urandom_range(3)), 8'($urandom), 5'($urandom));
        end
      end
    end
  endtask

  // table fill with no idling on either side
  task automatic test_back_to_back();
    gaps_on <= 1'b0;
    test_table_fill();
    gaps_on <= 1'b1;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= !(gaps_on && $urandom_range(99) < 8);
  end

  always @(posedge clk_i) begin
    status_t got;
    status_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.frame_ok  = out_if.frame_ok;
      got.kind      = kind_e'(out_if.frame_kind);
      got.action    = act_e'(out_if.action);
      got.del_seen  = out_if.delete_header_seen;
      got.count     = out_if.waypoint_count;
      got.fm_lat    = out_if.follow_latitude;
      got.fm_lng    = out_if.follow_longitude;
      got.entry_lat = out_if.entry_latitude;
      got.entry_lng = out_if.entry_longitude;
      if (status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("status beat with nothing expected");
      end else begin
        want = status_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("status mismatch: exp ok=%0d kind=%0d act=%0d del=%0d cnt=%0d",
                     want.frame_ok, want.kind, want.action, want.del_seen, want.count);
            $display("  exp follow=%h,%h entry=%h,%h",
                     want.fm_lat, want.fm_lng, want.entry_lat, want.entry_lng);
            $display("  got ok=%0d kind=%0d act=%0d del=%0d cnt=%0d",
                     got.frame_ok, got.kind, got.action, got.del_seen, got.count);
            $display("  got follow=%h,%h entry=%h,%h",
                     got.fm_lat, got.fm_lng, got.entry_lat, got.entry_lng);
          end
        end
      end
    end
  end

  // no beat on either channel for too long means the block hung
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < FrameBytes; i++) frame_buf[i] = '0;
    for (int i = 0; i < WaypointSlots; i++) begin
      wp_lat[i] = '0;
      wp_lng[i] = '0;
    end
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_BYTE;
    in_if.rx_byte     <= '0;
    in_if.entry_index <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_MIN_LAT;
    cfg_data_i        <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_status_idle();
    test_frame_cases();
    test_random_traffic(40);
    set_limits(32'h80000000, 32'h80000000);
    test_back_to_back();
    set_limits(32'h7fffffff, 32'h7fffffff);
    test_random_traffic(30);
    set_limits($urandom, $urandom);
    test_random_traffic(30);
    set_limits(32'h0, 32'h0);
    test_random_traffic(30);

    drain_status();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wfr_pkg.sv
hdl/wfr_if.sv
hdl/wfr_ram.sv
hdl/wfr_frame_buf.sv
hdl/waypoint_frame_receiver.sv
bench/waypoint_frame_receiver_tb.sv
